>>> hw/rtl/gbr_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian blur package
// Shared constants, register indexes and word types of the RGB blur core.
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HALF  = 4;
  localparam int NUM_WEIGHTS   = 5;
  localparam int WEIGHT_W      = 17;
  localparam int FRAME_W_W     = 11;
  localparam int FRAME_H_W     = 12;
  localparam int HALF_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FOUR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd7;

  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weights_t;

  typedef struct packed {
    logic       action;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_done;
  } out_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic issue;
    logic keep;
    logic first;
    logic last;
  } tap_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/gbr_mac.sv
// ----------------------------------------------------------------------------
// Gaussian blur tap accumulator
// Forms each tap weight, scales the pixel read from the line store and sums
// one window per channel, then rounds and clamps the sums to eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_mac #(
  parameter int MAX_HALF = gbr_pkg::DEF_MAX_HALF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire gbr_pkg::weights_t                weights,
  input  wire gbr_pkg::tap_ctrl_t               tap,
  input  wire logic [$clog2(MAX_HALF+1)-1:0]    dist_y,
  input  wire logic [$clog2(MAX_HALF+1)-1:0]    dist_x,
  input  wire gbr_pkg::rgb_t                    pixel,
  output logic                                  res_valid,
  output gbr_pkg::rgb_t                         result
);

  localparam int DIST_W = $clog2(MAX_HALF+1);
  localparam int WT_W   = 2 * gbr_pkg::WEIGHT_W;
  localparam int PROD_W = WT_W + 8;
  localparam int ACC_W  = PROD_W + $clog2((2*MAX_HALF+1) * (2*MAX_HALF+1));

  function automatic logic [gbr_pkg::WEIGHT_W-1:0] pick_weight(
    input gbr_pkg::weights_t w,
    input logic [DIST_W-1:0] d
  );
    logic [gbr_pkg::WEIGHT_W-1:0] sel;
    sel = '0;
    for (int i = 0; i < gbr_pkg::NUM_WEIGHTS; i++) begin
      if (32'(d) == i) sel = w[i];
    end
    return sel;
  endfunction

  function automatic logic [7:0] finish(input logic [ACC_W-1:0] acc);
    logic [ACC_W:0] sum;
    logic [ACC_W-32:0] q;
    sum = {1'b0, acc} + (ACC_W+1)'(64'h8000_0000);
    q = sum[ACC_W:32];
    return (|q[ACC_W-32:8]) ? 8'hFF : q[7:0];
  endfunction

  gbr_pkg::tap_ctrl_t ctrl1;
  gbr_pkg::tap_ctrl_t ctrl2;
  logic [WT_W-1:0]    wt1;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_g;
  logic [PROD_W-1:0]  prod_b;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_g;
  logic [ACC_W-1:0]   acc_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1     <= '0;
      ctrl2     <= '0;
      res_valid <= 1'b0;
    end else begin
      ctrl1     <= tap;
      ctrl2     <= ctrl1;
      res_valid <= ctrl2.issue && ctrl2.last;
    end
  end

  always_ff @(posedge clk) begin
    wt1 <= WT_W'(pick_weight(weights, dist_y)) * WT_W'(pick_weight(weights, dist_x));
    if (ctrl1.keep) begin
      prod_r <= PROD_W'(wt1) * PROD_W'(pixel.red);
      prod_g <= PROD_W'(wt1) * PROD_W'(pixel.green);
      prod_b <= PROD_W'(wt1) * PROD_W'(pixel.blue);
    end else begin
      prod_r <= '0;
      prod_g <= '0;
      prod_b <= '0;
    end
    if (ctrl2.issue) begin
      if (ctrl2.first) begin
        acc_r <= ACC_W'(prod_r);
        acc_g <= ACC_W'(prod_g);
        acc_b <= ACC_W'(prod_b);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
        acc_g <= acc_g + ACC_W'(prod_g);
        acc_b <= acc_b + ACC_W'(prod_b);
      end
    end
  end

  always_comb begin
    result.red   = finish(acc_r);
    result.green = finish(acc_g);
    result.blue  = finish(acc_b);
  end

endmodule

`default_nettype wire

>>> hw/rtl/gaussian_blur_rgb_core.sv
// ----------------------------------------------------------------------------
// Gaussian blur RGB core
// Streaming separable Gaussian blur of RGB pixels with zero frame borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order as words on the in channel (valid/ready).
// A flush word stands for a zero pixel past the frame and pushes out the
// trailing results; a flush at the very start of a frame is dropped.
// A result word leaves on the out channel half_width rows plus half_width
// pixels after its own pixel entered; frame_done marks the last one.
// Each input word but a dropped flush is written to a line store memory in
// the cycle it is accepted. A word that releases a result then walks the
// window through the single read port of that memory, one tap per cycle,
// and no new word is taken until its result is loaded into the output
// register; a word without a result leaves the block idle. While the
// receiver stalls, the block finishes the next word's taps and then holds
// until the register is taken. Reset restores the register defaults and
// starts a new frame. Configuration is written through
// cfg_we/cfg_index/cfg_data, by the user only while idle; the block does
// not enforce it. Geometry writes restart the frame, weights act at once.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_rgb_core #(
  parameter int MAX_WIDTH = gbr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = gbr_pkg::DEF_MAX_HALF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire gbr_pkg::in_word_t                 in_word,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output gbr_pkg::out_word_t                     out_word,
  input  wire logic                              cfg_we,
  input  wire logic [gbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gbr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int HW     = $clog2(MAX_HALF+1);
  localparam int WW     = $clog2(MAX_WIDTH+1);
  localparam int DW     = $clog2(2*MAX_HALF+1);
  localparam int AW     = $clog2(2*MAX_HALF*(MAX_WIDTH+1)+1);
  localparam int DEPTH  = 1 << AW;
  localparam int DLY_W  = $clog2(MAX_HALF*(MAX_WIDTH+1)+1);
  localparam int POS_W  =
    $clog2(MAX_WIDTH*(1 << gbr_pkg::FRAME_H_W) + MAX_HALF*(MAX_WIDTH+1) + 1);
  localparam int RS_W   = gbr_pkg::FRAME_H_W + 1;
  localparam int CS_W   = WW + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_TAP    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [gbr_pkg::HALF_W-1:0]    half_width;
  gbr_pkg::weights_t             weights;
  logic [gbr_pkg::FRAME_W_W-1:0] frame_width;
  logic [gbr_pkg::FRAME_H_W-1:0] frame_height;

  logic [1:0]                    state;
  logic [POS_W-1:0]              pos;
  logic [gbr_pkg::FRAME_H_W-1:0] out_row;
  logic [WW-1:0]                 out_col;
  logic [gbr_pkg::FRAME_H_W-1:0] job_r;
  logic [WW-1:0]                 job_c;
  logic                          job_done;
  logic [AW-1:0]                 row_addr;
  logic [DW-1:0]                 dy;
  logic [DW-1:0]                 dx;

  logic [HW-1:0]                 h_eff;
  logic [WW-1:0]                 w_eff;
  logic [gbr_pkg::FRAME_H_W-1:0] ht_eff;
  logic [DLY_W-1:0]              delay;
  logic [POS_W-1:0]              frame_px;
  logic [DW-1:0]                 two_h;
  logic                          in_fire;
  logic                          skip;
  logic                          has_out;
  logic                          is_pix;
  logic                          done_now;
  logic [AW-1:0]                 top_left;
  logic [AW-1:0]                 issue_addr;
  logic [RS_W-1:0]               rsum;
  logic [CS_W-1:0]               csum;
  logic                          out_load;

  logic [23:0]                   mem [DEPTH];
  logic [23:0]                   rd_q;
  logic                          mem_we;
  logic [23:0]                   mem_wd;

  gbr_pkg::tap_ctrl_t            tap;
  logic [HW-1:0]                 dist_y;
  logic [HW-1:0]                 dist_x;
  gbr_pkg::rgb_t                 pixel;
  logic                          res_valid;
  gbr_pkg::rgb_t                 result;

  always_comb begin
    h_eff = (32'(half_width) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_width);
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    ht_eff   = (frame_height == '0) ? gbr_pkg::FRAME_H_W'(1) : frame_height;
    delay    = DLY_W'(h_eff) * DLY_W'(w_eff) + DLY_W'(h_eff);
    frame_px = POS_W'(w_eff) * POS_W'(ht_eff);
    two_h    = DW'({h_eff, 1'b0});
  end

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign skip     = (in_word.action == gbr_pkg::ACTION_FLUSH) && (pos == '0);
  assign has_out  = pos >= POS_W'(delay);
  assign is_pix   = (in_word.action == gbr_pkg::ACTION_PIXEL) && (pos < frame_px);
  assign done_now = ({1'b0, pos} + (POS_W+1)'(1)) >=
                    ((POS_W+1)'(frame_px) + (POS_W+1)'(delay));
  assign top_left = pos[AW-1:0] - AW'({delay, 1'b0});
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  assign mem_we = in_fire && !skip;
  assign mem_wd = is_pix ? {in_word.red_in, in_word.green_in, in_word.blue_in} : 24'd0;

  always_ff @(posedge clk) begin
    if (mem_we) mem[pos[AW-1:0]] <= mem_wd;
    rd_q <= mem[issue_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width   <= gbr_pkg::HALF_W'(1);
      weights      <= {{((gbr_pkg::NUM_WEIGHTS-1)*gbr_pkg::WEIGHT_W){1'b0}},
                       gbr_pkg::WEIGHT_W'(65536)};
      frame_width  <= gbr_pkg::FRAME_W_W'(640);
      frame_height <= gbr_pkg::FRAME_H_W'(480);
      state        <= ST_IDLE;
      pos          <= '0;
      out_row      <= '0;
      out_col      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          gbr_pkg::REG_HALF_WIDTH: begin
            half_width <= cfg_data[gbr_pkg::HALF_W-1:0];
            pos        <= '0;
            out_row    <= '0;
            out_col    <= '0;
          end
          gbr_pkg::REG_WEIGHT_CENTER: weights[0] <= cfg_data;
          gbr_pkg::REG_WEIGHT_ONE:    weights[1] <= cfg_data;
          gbr_pkg::REG_WEIGHT_TWO:    weights[2] <= cfg_data;
          gbr_pkg::REG_WEIGHT_THREE:  weights[3] <= cfg_data;
          gbr_pkg::REG_WEIGHT_FOUR:   weights[4] <= cfg_data;
          gbr_pkg::REG_FRAME_WIDTH: begin
            frame_width <= cfg_data[gbr_pkg::FRAME_W_W-1:0];
            pos         <= '0;
            out_row     <= '0;
            out_col     <= '0;
          end
          gbr_pkg::REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data[gbr_pkg::FRAME_H_W-1:0];
            pos          <= '0;
            out_row      <= '0;
            out_col      <= '0;
          end
          default: ;
        endcase
      end else if (mem_we) begin
        if (has_out && done_now) begin
          pos     <= '0;
          out_row <= '0;
          out_col <= '0;
        end else begin
          pos <= pos + POS_W'(1);
          if (has_out) begin
            if (out_col == w_eff - WW'(1)) begin
              out_col <= '0;
              out_row <= out_row + gbr_pkg::FRAME_H_W'(1);
            end else begin
              out_col <= out_col + WW'(1);
            end
          end
        end
      end
      case (state)
        ST_IDLE: begin
          if (mem_we && has_out) state <= ST_TAP;
        end
        ST_TAP: begin
          if (dx == two_h && dy == two_h) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (res_valid) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && mem_we && has_out) begin
      job_r    <= out_row;
      job_c    <= out_col;
      job_done <= done_now;
      row_addr <= top_left;
      dy       <= '0;
      dx       <= '0;
    end else if (state == ST_TAP) begin
      if (dx == two_h) begin
        dx       <= '0;
        dy       <= dy + DW'(1);
        row_addr <= row_addr + AW'(w_eff);
      end else begin
        dx <= dx + DW'(1);
      end
    end
    if (out_load) begin
      out_word.red_out    <= result.red;
      out_word.green_out  <= result.green;
      out_word.blue_out   <= result.blue;
      out_word.frame_done <= job_done;
    end
  end

  always_comb begin
    issue_addr = row_addr + AW'(dx);
    rsum       = RS_W'(job_r) + RS_W'(dy);
    csum       = CS_W'(job_c) + CS_W'(dx);
    tap.issue  = (state == ST_TAP);
    tap.keep   = (state == ST_TAP) &&
                 (rsum >= RS_W'(h_eff)) && (rsum < RS_W'(ht_eff) + RS_W'(h_eff)) &&
                 (csum >= CS_W'(h_eff)) && (csum < CS_W'(w_eff) + CS_W'(h_eff));
    tap.first  = (dy == '0) && (dx == '0);
    tap.last   = (dy == two_h) && (dx == two_h);
    dist_y     = (dy > DW'(h_eff)) ? HW'(dy - DW'(h_eff)) : HW'(DW'(h_eff) - dy);
    dist_x     = (dx > DW'(h_eff)) ? HW'(dx - DW'(h_eff)) : HW'(DW'(h_eff) - dx);
    pixel      = rd_q;
  end

  gbr_mac #(
    .MAX_HALF (MAX_HALF)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .weights   (weights),
    .tap       (tap),
    .dist_y    (dist_y),
    .dist_x    (dist_x),
    .pixel     (pixel),
    .res_valid (res_valid),
    .result    (result)
  );

  a_res_in_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == ST_DRAIN)
    else $error("window sum finished outside the drain state");

  a_tap_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAP |-> dy <= two_h && dx <= two_h)
    else $error("tap counters ran past the window");

  a_done_restart: assert property (@(posedge clk) disable iff (rst)
    out_load && job_done |-> pos == '0)
    else $error("frame end result without frame restart");

endmodule

`default_nettype wire
